/* design/packed_pixel_store_top_defines.svh */
// ----------------------------------------------------------------------------
// packed_pixel_store_top_defines
// assertion macros used by the packed pixel store top
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_STORE_TOP_DEFINES_SVH
`define PACKED_PIXEL_STORE_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define PPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// shared widths, codes and control types of the packed pixel store
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int BYTE_W      = 8;
    localparam int DEPTH_W     = 4;
    localparam int LIMIT_W     = 13;
    localparam int INDEX_W     = 15;
    localparam int CFG_W       = 13;
    localparam int REG_INDEX_W = 1;
    localparam int BIT_POS_W   = 19;
    localparam int FIRST_W     = 16;
    localparam int SHIFT_W     = 3;
    localparam int WORD_W      = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam int DEFAULT_STORE_BYTES = 4096;

    localparam logic [DEPTH_W-1:0] BPE_RESET = 4'd1;
    localparam logic [LIMIT_W-1:0] BIU_RESET = 13'd4096;
    localparam logic [DEPTH_W-1:0] DEPTH_MIN = 4'd1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd8;

    // configuration register indexes
    localparam logic [REG_INDEX_W-1:0] REG_BITS_PER_ENTRY = 1'b0;
    localparam logic [REG_INDEX_W-1:0] REG_BYTES_IN_USE   = 1'b1;

    // opcodes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic commit;
        logic load_out;
    } pps_cmd_t;

endpackage

/* design/pps_ram.sv */
// ----------------------------------------------------------------------------
// pps_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pps_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/pps_datapath.sv */
// ----------------------------------------------------------------------------
// pps_datapath
// config registers, address math, even/odd byte banks and result register
// ----------------------------------------------------------------------------
module pps_datapath
    import pps_pkg::*;
#(
    parameter int STORE_BYTES = DEFAULT_STORE_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pps_cmd_t               cmd,
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int EVEN_DEPTH = (STORE_BYTES + 1) / 2;
    localparam int ODD_DEPTH  = STORE_BYTES / 2;
    localparam int EVEN_AW    = (EVEN_DEPTH > 1) ? $clog2(EVEN_DEPTH) : 1;
    localparam int ODD_AW     = (ODD_DEPTH > 1) ? $clog2(ODD_DEPTH) : 1;
    localparam logic [FIRST_W:0] STORE_LIM = (FIRST_W + 1)'(STORE_BYTES);

    // configuration
    logic [DEPTH_W-1:0] bpe_reg;
    logic [LIMIT_W-1:0] biu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpe_reg <= BPE_RESET;
            biu_reg <= BIU_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BITS_PER_ENTRY: bpe_reg <= cfg_data[DEPTH_W-1:0];
                REG_BYTES_IN_USE:   biu_reg <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // input fields
    logic               in_op;
    logic [INDEX_W-1:0] in_index;
    logic [BYTE_W-1:0]  in_value;

    assign in_op    = s_tdata[0];
    assign in_index = s_tdata[INDEX_W:1];
    assign in_value = s_tdata[IN_TDATA_W-1:INDEX_W+1];

    // address math for the item being accepted
    logic [DEPTH_W-1:0]   depth_eff;
    logic [BIT_POS_W-1:0] bit_pos;
    logic [FIRST_W-1:0]   first;
    logic [FIRST_W:0]     limit;
    logic [FIRST_W:0]     first_ext;
    logic [FIRST_W:0]     even_addr_full;
    logic [FIRST_W-1:0]   odd_addr_full;
    logic [BYTE_W:0]      mask_wide;
    logic                 in_oor;
    logic                 in_has_next;
    logic                 even_rd_en;
    logic                 odd_rd_en;

    always_comb
    begin
        if (bpe_reg < DEPTH_MIN)
        begin
            depth_eff = DEPTH_MIN;
        end
        else if (bpe_reg > DEPTH_MAX)
        begin
            depth_eff = DEPTH_MAX;
        end
        else
        begin
            depth_eff = bpe_reg;
        end
        bit_pos        = BIT_POS_W'(in_index) * BIT_POS_W'(depth_eff);
        first          = bit_pos[BIT_POS_W-1:SHIFT_W];
        first_ext      = (FIRST_W + 1)'(first);
        limit          = ((FIRST_W + 1)'(biu_reg) > STORE_LIM) ? STORE_LIM
                                                               : (FIRST_W + 1)'(biu_reg);
        in_oor         = (first_ext >= limit);
        in_has_next    = ((first_ext + 1'b1) < limit);
        // even bank holds byte 2k, odd bank byte 2k+1
        even_addr_full = (first_ext + 1'b1) >> 1;
        odd_addr_full  = first >> 1;
        mask_wide      = ((BYTE_W + 1)'(1) << depth_eff) - 1'b1;
        even_rd_en     = cmd.accept && !in_oor && (!first[0] || in_has_next);
        odd_rd_en      = cmd.accept && !in_oor && (first[0] || in_has_next);
    end

    // item registers, held through modify and hold
    logic               op_reg;
    logic [BYTE_W-1:0]  value_reg;
    logic [BYTE_W-1:0]  mask_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic               oor_reg;
    logic               has_next_reg;
    logic               first_odd_reg;
    logic [EVEN_AW-1:0] even_addr_reg;
    logic [ODD_AW-1:0]  odd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg        <= in_op;
            value_reg     <= in_value;
            mask_reg      <= mask_wide[BYTE_W-1:0];
            shift_reg     <= bit_pos[SHIFT_W-1:0];
            oor_reg       <= in_oor;
            has_next_reg  <= in_has_next;
            first_odd_reg <= first[0];
            even_addr_reg <= even_addr_full[EVEN_AW-1:0];
            odd_addr_reg  <= odd_addr_full[ODD_AW-1:0];
        end
    end

    // byte banks
    logic [BYTE_W-1:0] even_rd_data;
    logic [BYTE_W-1:0] odd_rd_data;
    logic [BYTE_W-1:0] even_wr_data;
    logic [BYTE_W-1:0] odd_wr_data;
    logic              even_wr_en;
    logic              odd_wr_en;

    pps_ram
    #(
        .WIDTH (BYTE_W),
        .DEPTH (EVEN_DEPTH)
    )
    u_even_bank
    (
        .clk     (clk),
        .wr_en   (even_wr_en),
        .wr_addr (even_addr_reg),
        .wr_data (even_wr_data),
        .rd_en   (even_rd_en),
        .rd_addr (even_addr_full[EVEN_AW-1:0]),
        .rd_data (even_rd_data)
    );

    pps_ram
    #(
        .WIDTH (BYTE_W),
        .DEPTH (ODD_DEPTH)
    )
    u_odd_bank
    (
        .clk     (clk),
        .wr_en   (odd_wr_en),
        .wr_addr (odd_addr_reg),
        .wr_data (odd_wr_data),
        .rd_en   (odd_rd_en),
        .rd_addr (odd_addr_full[ODD_AW-1:0]),
        .rd_data (odd_rd_data)
    );

    // read-modify-write of the 16-bit word
    logic [BYTE_W-1:0] lo_byte;
    logic [BYTE_W-1:0] hi_byte;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] field_mask;
    logic [WORD_W-1:0] new_word;
    logic [BYTE_W-1:0] entry;
    logic [BYTE_W-1:0] result_value;
    logic              do_write;

    always_comb
    begin
        lo_byte      = first_odd_reg ? odd_rd_data : even_rd_data;
        hi_byte      = has_next_reg ? (first_odd_reg ? even_rd_data : odd_rd_data)
                                    : '0;
        word         = {hi_byte, lo_byte};
        field_mask   = WORD_W'(mask_reg) << shift_reg;
        new_word     = (word & ~field_mask) | (WORD_W'(value_reg & mask_reg) << shift_reg);
        entry        = BYTE_W'(word >> shift_reg) & mask_reg;
        result_value = ((op_reg == OP_READ) && !oor_reg) ? entry : '0;
        do_write     = cmd.commit && (op_reg == OP_WRITE) && !oor_reg;
        even_wr_en   = do_write && (!first_odd_reg || has_next_reg);
        odd_wr_en    = do_write && (first_odd_reg || has_next_reg);
        even_wr_data = first_odd_reg ? new_word[WORD_W-1:BYTE_W] : new_word[BYTE_W-1:0];
        odd_wr_data  = first_odd_reg ? new_word[BYTE_W-1:0] : new_word[WORD_W-1:BYTE_W];
    end

    // result register
    logic [BYTE_W-1:0] out_value_reg;
    logic              out_oor_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg <= result_value;
            out_oor_reg   <= oor_reg;
        end
    end

    assign m_tdata = {(OUT_TDATA_W - BYTE_W - 1)'(0), out_oor_reg, out_value_reg};

endmodule

/* design/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl
// item sequencer and result valid flag
// ----------------------------------------------------------------------------
module pps_ctrl
    import pps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output pps_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MODIFY = 3'b010,
        S_HOLD   = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    always_comb
    begin
        slot_free    = !out_valid_reg || m_tready;
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.commit   = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                cmd.commit = 1'b1;
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.load_out || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

/* design/packed_pixel_store_top.sv */
// ----------------------------------------------------------------------------
// packed_pixel_store_top
// packed pixel store: byte memory of pixels packed at 1 to 8 bits per entry
// ----------------------------------------------------------------------------
// Each input beat reads or writes one packed entry; entry n starts at bit
// n * depth of the byte store, lsb first, and may straddle two bytes. For
// each beat the accept cycle issues the reads of the first byte and the
// following byte, and the next cycle merges them into a 16-bit word, writes
// the bytes back for a write and loads the result register once the result
// slot is free. The two bytes always come from different banks (even and
// odd byte addresses), so the whole read-modify-write needs one read and
// one write per bank. The result register lets a new beat be taken while
// a result still waits; a result that is not taken for longer stalls the
// next beat in the hold state after its modify step. Accesses whose first
// byte lies at or beyond min(bytes_in_use, STORE_BYTES) are not performed
// and return out_of_range set with read_value zero. A depth of zero acts
// as one and depths above eight act as eight. Reading bits that were never
// written returns undefined data. Configuration must be written only while
// no beat is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "packed_pixel_store_top_defines.svh"

module packed_pixel_store_top
    import pps_pkg::*;
#(
    parameter int STORE_BYTES = DEFAULT_STORE_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write port
    input  logic                   cfg_we,
    input  logic [REG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,

    // access beats
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] opcode, [15:1] pixel_index, [23:16] pixel_value
    input  logic [IN_TDATA_W-1:0]  s_tdata,

    // result beats
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] read_value, [8] out_of_range, [15:9] zero
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    pps_cmd_t cmd;

    // sequencer: idle/accept, modify, hold while the result slot is busy
    pps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // address math, banks and the result register
    pps_datapath
    #(
        .STORE_BYTES (STORE_BYTES)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata)
    );

    // an accepted beat is always followed by its modify cycle
    `PPS_ASSERT_NEXT(a_accept_then_commit, clk, rst_n, s_tvalid && s_tready,
                     cmd.commit, "accepted beat did not reach modify")

    // no new beat is taken while one is being modified
    `PPS_ASSERT_NOW(a_commit_not_ready, clk, rst_n, cmd.commit, !s_tready,
                    "ready during modify")

    // the result register is only reloaded when its old beat is gone
    `PPS_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.load_out, !m_tvalid || m_tready,
                    "result overwritten before taken")

endmodule
